@@ src/fps_pkg.sv @@
// Package for the fast packet segmenter: field widths, register indexes,
// frame constants and the structs passed between the segmenter modules.
// No dependencies.
package fps_pkg;

	localparam int unsigned MAX_MESSAGE_BYTES_DEF = 223;

	localparam int unsigned MSG_ID_W  = 29;
	localparam int unsigned SEQ_W     = 3;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned COUNTER_W = 5;
	localparam int unsigned FILL_W    = 3;
	localparam int unsigned DLC_W     = 4;
	localparam int unsigned FRAME_BYTES = 8;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_ADDRESS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TX_MUTE        = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LINK_OK        = 2'd2;

	localparam logic [BYTE_W-1:0] SOURCE_ADDRESS_RST = 8'hFF;

	// payload bytes per frame: first frame also carries the total length
	localparam logic [FILL_W-1:0] FIRST_CAP  = 3'd6;
	localparam logic [FILL_W-1:0] NEXT_CAP   = 3'd7;
	localparam logic [FILL_W-1:0] FIRST_BASE = 3'd2;
	localparam logic [FILL_W-1:0] NEXT_BASE  = 3'd1;

	typedef struct packed {
		logic [MSG_ID_W-1:0] message_id;
		logic [SEQ_W-1:0]    sequence_id;
		logic [BYTE_W-1:0]   message_length;
		logic [BYTE_W-1:0]   payload_byte;
		logic                last_byte;
	} msg_beat_t;

	typedef struct packed {
		logic [MSG_ID_W-1:0]                   frame_id;
		logic [DLC_W-1:0]                      frame_length;
		logic [FRAME_BYTES-1:0][BYTE_W-1:0]    data;
		logic                                  last_frame;
	} frame_t;

	typedef struct packed {
		logic   close;
		frame_t frame;
	} asm_out_t;

endpackage

@@ src/fps_msg_if.sv @@
// Message byte channel of the fast packet segmenter: valid/ready plus payload.
// Depends on fps_pkg.
interface fps_msg_if;
	import fps_pkg::*;

	logic                valid;
	logic                ready;
	logic [MSG_ID_W-1:0] message_id;
	logic [SEQ_W-1:0]    sequence_id;
	logic [BYTE_W-1:0]   message_length;
	logic [BYTE_W-1:0]   payload_byte;
	logic                last_byte;

	modport source (
		output valid, message_id, sequence_id, message_length, payload_byte, last_byte,
		input  ready
	);

	modport sink (
		input  valid, message_id, sequence_id, message_length, payload_byte, last_byte,
		output ready
	);

endinterface

@@ src/fps_frame_if.sv @@
// CAN frame channel of the fast packet segmenter: valid/ready plus frame fields.
// Depends on fps_pkg.
interface fps_frame_if;
	import fps_pkg::*;

	logic                valid;
	logic                ready;
	logic [MSG_ID_W-1:0] frame_id;
	logic [DLC_W-1:0]    frame_length;
	logic [BYTE_W-1:0]   data0;
	logic [BYTE_W-1:0]   data1;
	logic [BYTE_W-1:0]   data2;
	logic [BYTE_W-1:0]   data3;
	logic [BYTE_W-1:0]   data4;
	logic [BYTE_W-1:0]   data5;
	logic [BYTE_W-1:0]   data6;
	logic [BYTE_W-1:0]   data7;
	logic                last_frame;

	modport source (
		output valid, frame_id, frame_length, data0, data1, data2, data3, data4, data5,
			data6, data7, last_frame,
		input  ready
	);

	modport sink (
		input  valid, frame_id, frame_length, data0, data1, data2, data3, data4, data5,
			data6, data7, last_frame,
		output ready
	);

endinterface

@@ src/fps_assembler.sv @@
// Frame assembler: holds the frame being filled, the frame counter and the
// message byte count, and builds the finished frame on the closing beat.
// Depends on fps_pkg.
module fps_assembler #(
	parameter int unsigned MAX_MESSAGE_BYTES = fps_pkg::MAX_MESSAGE_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          beat_en,
	input  fps_pkg::msg_beat_t            beat,
	input  logic [fps_pkg::BYTE_W-1:0]    source_address,
	output fps_pkg::asm_out_t             result
);
	import fps_pkg::*;

	localparam int unsigned CountW = $clog2(MAX_MESSAGE_BYTES + 1);
	localparam logic [CountW-1:0] MaxCount = CountW'(MAX_MESSAGE_BYTES);

	logic [COUNTER_W-1:0] counter_q;
	logic [FILL_W-1:0]    fill_q;
	logic [CountW-1:0]    count_q;
	logic [BYTE_W-1:0]    store_q [1:FRAME_BYTES-1];

	logic                 first;
	logic [FILL_W-1:0]    base;
	logic [FILL_W-1:0]    cap;
	logic [FILL_W-1:0]    idx;
	logic [FILL_W-1:0]    fill_nx;
	logic [CountW-1:0]    total;
	logic                 ends;
	logic                 close;

	always_comb begin
		first   = (counter_q == '0);
		base    = first ? FIRST_BASE : NEXT_BASE;
		cap     = first ? FIRST_CAP : NEXT_CAP;
		idx     = base + fill_q;
		fill_nx = fill_q + 3'd1;
		total   = count_q + CountW'(1);
		ends    = beat.last_byte || (total >= MaxCount);
		close   = (fill_nx >= cap) || ends;
	end

	always_comb begin
		result.close              = close;
		result.frame.frame_id     = {beat.message_id[MSG_ID_W-1:BYTE_W], source_address};
		result.frame.frame_length = {1'b0, fill_nx} + {1'b0, base};
		result.frame.last_frame   = ends;
		result.frame.data[0]      = {beat.sequence_id, counter_q};
		for (int j = 1; j < FRAME_BYTES; j++) begin
			result.frame.data[j] = (idx == FILL_W'(j)) ? beat.payload_byte : store_q[j];
		end
		if (first) begin
			result.frame.data[1] = beat.message_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			fill_q    <= '0;
			count_q   <= '0;
			for (int j = 1; j < FRAME_BYTES; j++) begin
				store_q[j] <= '0;
			end
		end else if (beat_en) begin
			if (close) begin
				fill_q    <= '0;
				count_q   <= ends ? '0 : total;
				counter_q <= ends ? '0 : counter_q + 5'd1;
				for (int j = 1; j < FRAME_BYTES; j++) begin
					store_q[j] <= '0;
				end
			end else begin
				fill_q       <= fill_nx;
				count_q      <= total;
				store_q[idx] <= beat.payload_byte;
			end
		end
	end

	a_fill_below_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(counter_q == '0) ? (fill_q < FIRST_CAP) : (fill_q < NEXT_CAP))
		else $error("fill position reached frame capacity");

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) == ((counter_q == '0) ? int'(fill_q)
			: 6 + 7 * (int'(counter_q) - 1) + int'(fill_q)))
		else $error("byte count out of step with frame counter");

	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		beat_en && close && ends |=> (counter_q == '0) && (count_q == '0) && (fill_q == '0))
		else $error("message end did not restart the frame sequence");

endmodule

@@ src/fast_packet_segmenter.sv @@
// Fast packet segmenter top level: configuration registers, frame assembler
// and the registered frame output. Depends on fps_pkg, fps_msg_if,
// fps_frame_if and fps_assembler.
//
// Usage: message bytes arrive one beat at a time on msg, each carrying the
// identifier, sequence id, total length, one payload byte and a last flag.
// Finished CAN frames leave on frame: identifier with the source address in
// its low byte, length code, eight data bytes and a last-frame flag.
// A frame closes when it holds 6 (first) or 7 (later) payload bytes, on the
// last byte, or when the message reaches MAX_MESSAGE_BYTES.
// The frame appears on frame.valid in the cycle after the beat that
// closes it. Throughput: one byte per cycle; msg.ready is low only while a
// frame sits in the output register and frame.ready is low.
// While tx_mute is 1 or link_ok is 0, bytes are still taken and frames built,
// but none is sent. Write configuration through cfg_we/cfg_index/cfg_data.
// Reset clears the frame in progress, the output valid flag and the
// configuration (source address 255, unmuted, link down).
module fast_packet_segmenter #(
	parameter int unsigned MAX_MESSAGE_BYTES = fps_pkg::MAX_MESSAGE_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fps_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [fps_pkg::CFG_DATA_W-1:0]   cfg_data,
	fps_msg_if.sink                          msg,
	fps_frame_if.source                      frame
);
	import fps_pkg::*;

	logic [BYTE_W-1:0] source_address_q;
	logic              tx_mute_q;
	logic              link_ok_q;

	msg_beat_t beat;
	asm_out_t  asm_out;
	frame_t    frame_q;
	logic      out_valid_q;
	logic      accept;
	logic      tx_en;
	logic      load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_address_q <= SOURCE_ADDRESS_RST;
			tx_mute_q        <= 1'b0;
			link_ok_q        <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SOURCE_ADDRESS: source_address_q <= cfg_data;
				REG_TX_MUTE:        tx_mute_q        <= cfg_data[0];
				REG_LINK_OK:        link_ok_q        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign beat = '{
		message_id:     msg.message_id,
		sequence_id:    msg.sequence_id,
		message_length: msg.message_length,
		payload_byte:   msg.payload_byte,
		last_byte:      msg.last_byte
	};

	assign msg.ready = !out_valid_q || frame.ready;
	assign accept    = msg.valid && msg.ready;
	assign tx_en     = link_ok_q && !tx_mute_q;
	assign load      = accept && asm_out.close && tx_en;

	fps_assembler #(
		.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
	) u_assembler (
		.clk           (clk),
		.arst_n        (arst_n),
		.beat_en       (accept),
		.beat          (beat),
		.source_address(source_address_q),
		.result        (asm_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= asm_out.frame;
		end
	end

	assign frame.valid        = out_valid_q;
	assign frame.frame_id     = frame_q.frame_id;
	assign frame.frame_length = frame_q.frame_length;
	assign frame.data0        = frame_q.data[0];
	assign frame.data1        = frame_q.data[1];
	assign frame.data2        = frame_q.data[2];
	assign frame.data3        = frame_q.data[3];
	assign frame.data4        = frame_q.data[4];
	assign frame.data5        = frame_q.data[5];
	assign frame.data6        = frame_q.data[6];
	assign frame.data7        = frame_q.data[7];
	assign frame.last_frame   = frame_q.last_frame;

	a_closed_frame_sent: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid_q)
		else $error("closed frame not presented");

	a_taken_frame_drops: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && frame.ready && !load |=> !out_valid_q)
		else $error("taken frame presented again");

	a_length_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (frame_q.frame_length >= 4'd2) && (frame_q.frame_length <= 4'd8))
		else $error("frame length code out of range");

endmodule
